// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the barycentric weight pipeline
// Item layouts, datapath widths and fixed-point constants.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int FieldW   = 16;              // width of one input coordinate field
    localparam int CoordBits = 16;             // low bits of each field that are used
    localparam int FracBits = 16;              // fraction bits of the weights
    localparam int WeightW  = 32;              // weight width

    localparam int VecW     = CoordBits + 1;   // edge vector component
    localparam int ProdW    = 2 * VecW;        // component product
    localparam int DotW     = ProdW + 2;       // dot product (sum of three)
    localparam int HalfW    = DotW / 2;        // split point of the wide multiply
    localparam int WideW    = 2 * DotW;        // product of two dot products
    localparam int NumW     = WideW + 1;       // determinant / numerator
    localparam int QBits    = WeightW + 1;     // quotient bits incl. rounding bit
    localparam int PreShift = QBits - FracBits - 1;
    localparam int SumW     = WeightW + 2;     // weight_a before saturation

    localparam logic signed [SumW-1:0] WeightOne = SumW'(longint'(1) << FracBits);
    localparam logic signed [SumW-1:0] WeightMax =
        SumW'((longint'(1) << (WeightW - 1)) - 1);
    localparam logic signed [SumW-1:0] WeightMin =
        SumW'(-(longint'(1) << (WeightW - 1)));

    typedef logic signed [FieldW-1:0] t_field;

    typedef struct packed {
        t_field a_x;
        t_field a_y;
        t_field a_z;
        t_field b_x;
        t_field b_y;
        t_field b_z;
        t_field c_x;
        t_field c_y;
        t_field c_z;
        t_field q_x;
        t_field q_y;
        t_field q_z;
    } t_in;

    typedef struct packed {
        logic signed [WeightW-1:0] weight_a;
        logic signed [WeightW-1:0] weight_b;
        logic signed [WeightW-1:0] weight_c;
        logic                      degenerate;
    } t_out;

    // Sign-extend the used low bits of a coordinate field
    function automatic logic signed [VecW-1:0] coord(input t_field f);
        logic signed [CoordBits-1:0] c;
        c = f[CoordBits-1:0];
        return VecW'(c);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bcc_wmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_wmul: two-stage signed multiply of two dot products
// Splits each operand into halves, registers four partial products, then sums.
// ----------------------------------------------------------------------------
module bcc_wmul (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [bcc_pkg::DotW-1:0]     i_a,
    input  wire logic signed [bcc_pkg::DotW-1:0]     i_b,
    output logic signed [bcc_pkg::WideW-1:0]         o_p
);
    localparam int H = bcc_pkg::HalfW;
    localparam int W = bcc_pkg::WideW;

    logic signed [H-1:0]   a_hi, b_hi;
    logic        [H-1:0]   a_lo, b_lo;
    logic signed [2*H-1:0] r_hh, n_hh;
    logic signed [2*H:0]   r_hl, n_hl, r_lh, n_lh;
    logic        [2*H-1:0] r_ll, n_ll;
    logic signed [W-1:0]   r_p, n_p;

    assign a_hi = i_a[bcc_pkg::DotW-1:H];
    assign b_hi = i_b[bcc_pkg::DotW-1:H];
    assign a_lo = i_a[H-1:0];
    assign b_lo = i_b[H-1:0];

    // partial products
    always_comb begin
        n_hh = a_hi * b_hi;
        n_hl = a_hi * $signed({1'b0, b_lo});
        n_lh = b_hi * $signed({1'b0, a_lo});
        n_ll = a_lo * b_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
        end
    end

    // recombine
    assign n_p = (W'(r_hh) <<< (2 * H)) + (W'(r_hl) <<< H) + (W'(r_lh) <<< H) + W'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== rtl/bcc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_div: pipelined restoring divider with rounding and saturation
// One quotient bit per stage; gives round(mag * 2^FracBits / det), signed.
// ----------------------------------------------------------------------------
module bcc_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_vld,
    input  wire logic                                 i_neg,
    input  wire logic [bcc_pkg::NumW-1:0]             i_mag,
    input  wire logic [bcc_pkg::NumW-1:0]             i_det,
    output logic                                      o_vld,
    output logic                                      o_zero,
    output logic signed [bcc_pkg::WeightW-1:0]       o_weight
);
    localparam int N = bcc_pkg::NumW;
    localparam int Q = bcc_pkg::QBits;
    localparam logic [Q-1:0] LimPos = Q'((longint'(1) << (bcc_pkg::WeightW - 1)) - 1);
    localparam logic [Q-1:0] LimNeg = Q'(longint'(1) << (bcc_pkg::WeightW - 1));

    logic [N-1:0] r_rem [0:Q];
    logic [N-1:0] r_det [0:Q];
    logic [Q-1:0] r_low [0:Q];
    logic [Q-1:0] r_q   [0:Q];
    logic         r_neg [0:Q];
    logic         r_ovf [0:Q];
    logic         r_vld [0:Q];

    logic [N-1:0] top_rem;
    assign top_rem = i_mag >> bcc_pkg::PreShift;

    // entry: high part of the scaled numerator, overflow check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= top_rem;
            r_low[0] <= {i_mag[bcc_pkg::PreShift-1:0], (bcc_pkg::FracBits + 1)'(0)};
            r_q[0]   <= '0;
            r_det[0] <= i_det;
            r_neg[0] <= i_neg;
            r_ovf[0] <= (top_rem >= i_det);
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < Q; k++) begin : g_step
        logic [N:0] trial;
        logic       fits;

        assign trial = {r_rem[k], r_low[k][Q-1]};
        assign fits  = (trial >= {1'b0, r_det[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= fits ? N'(trial - {1'b0, r_det[k]}) : trial[N-1:0];
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][Q-2:0], fits};
                r_det[k+1] <= r_det[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // round half away from zero, saturate, apply sign
    logic [Q:0]   rnd;
    logic [Q-1:0] half, lim, mag;
    logic [bcc_pkg::WeightW-1:0] mag_w;

    always_comb begin
        rnd   = (Q + 1)'(r_q[Q]) + (Q + 1)'(1);
        half  = rnd[Q:1];
        lim   = r_neg[Q] ? LimNeg : LimPos;
        mag   = (r_ovf[Q] || (half > lim)) ? lim : half;
        mag_w = mag[bcc_pkg::WeightW-1:0];
    end

    logic                              r_ovld;
    logic                              r_zero;
    logic signed [bcc_pkg::WeightW-1:0] r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[Q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= (r_det[Q] == '0);
            r_w    <= r_neg[Q] ? -mag_w : mag_w;
        end
    end

    assign o_vld    = r_ovld;
    assign o_zero   = r_zero;
    assign o_weight = r_w;

endmodule
`default_nettype wire

// ===== rtl/triangle_barycentric_coords.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_barycentric_coords: barycentric weights of a point in a 3D triangle
// Edge vectors, dot products, Gram determinant, two pipelined dividers.
// ----------------------------------------------------------------------------
// Takes one query item per clock while o_in_ready is high, which it drops while
// the skid entry is full, and returns one result item per query, in order. Most
// of the pipeline is the two quotient dividers, which resolve one of 33 quotient
// bits per stage; ahead of them sit seven stages of edge vectors, component
// products, dot sums, a two-stage split 72-bit multiply, the determinant and
// numerator subtraction and magnitude extraction. Weights are signed Q15.16,
// rounded to nearest with ties away from zero and saturated to 32 bits; a zero
// determinant sets degenerate and forces all weights to zero. A two-entry
// output buffer lets input keep flowing while a result waits to be taken.
module triangle_barycentric_coords (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bcc_pkg::t_in  i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bcc_pkg::t_out      o_out_item
);
    localparam int VW = bcc_pkg::VecW;
    localparam int PW = bcc_pkg::ProdW;
    localparam int DW = bcc_pkg::DotW;
    localparam int NW = bcc_pkg::NumW;
    localparam int SW = bcc_pkg::SumW;
    localparam int WW = bcc_pkg::WeightW;

    logic en;
    logic r_skid_vld;
    assign en = !r_skid_vld;
    assign o_in_ready = en;

    // stage 1: edge vectors
    logic signed [VW-1:0] r_v0 [3];
    logic signed [VW-1:0] r_v1 [3];
    logic signed [VW-1:0] r_v2 [3];
    bcc_pkg::t_field pa [3], pb [3], pc [3], pq [3];
    logic r_vld1;

    always_comb begin
        pa[0] = i_in_item.a_x; pa[1] = i_in_item.a_y; pa[2] = i_in_item.a_z;
        pb[0] = i_in_item.b_x; pb[1] = i_in_item.b_y; pb[2] = i_in_item.b_z;
        pc[0] = i_in_item.c_x; pc[1] = i_in_item.c_y; pc[2] = i_in_item.c_z;
        pq[0] = i_in_item.q_x; pq[1] = i_in_item.q_y; pq[2] = i_in_item.q_z;
    end

    for (genvar k = 0; k < 3; k++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_v0[k] <= bcc_pkg::coord(pb[k]) - bcc_pkg::coord(pa[k]);
                r_v1[k] <= bcc_pkg::coord(pc[k]) - bcc_pkg::coord(pa[k]);
                r_v2[k] <= bcc_pkg::coord(pq[k]) - bcc_pkg::coord(pa[k]);
            end
        end
    end

    // stage 2: component products
    logic signed [PW-1:0] r_p00 [3], r_p01 [3], r_p11 [3], r_p20 [3], r_p21 [3];
    logic r_vld2;

    for (genvar k = 0; k < 3; k++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p00[k] <= r_v0[k] * r_v0[k];
                r_p01[k] <= r_v0[k] * r_v1[k];
                r_p11[k] <= r_v1[k] * r_v1[k];
                r_p20[k] <= r_v2[k] * r_v0[k];
                r_p21[k] <= r_v2[k] * r_v1[k];
            end
        end
    end

    // stage 3: dot products
    logic signed [DW-1:0] r_d00, r_d01, r_d11, r_d20, r_d21;
    logic r_vld3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d00 <= DW'(r_p00[0]) + DW'(r_p00[1]) + DW'(r_p00[2]);
            r_d01 <= DW'(r_p01[0]) + DW'(r_p01[1]) + DW'(r_p01[2]);
            r_d11 <= DW'(r_p11[0]) + DW'(r_p11[1]) + DW'(r_p11[2]);
            r_d20 <= DW'(r_p20[0]) + DW'(r_p20[1]) + DW'(r_p20[2]);
            r_d21 <= DW'(r_p21[0]) + DW'(r_p21[1]) + DW'(r_p21[2]);
        end
    end

    // stages 4-5: wide products
    logic signed [bcc_pkg::WideW-1:0] m00_11, m01_01, m11_20, m01_21, m00_21, m01_20;
    logic r_vld4, r_vld5;

    bcc_wmul u_m00_11 (.i_clk(i_clk), .i_en(en), .i_a(r_d00), .i_b(r_d11), .o_p(m00_11));
    bcc_wmul u_m01_01 (.i_clk(i_clk), .i_en(en), .i_a(r_d01), .i_b(r_d01), .o_p(m01_01));
    bcc_wmul u_m11_20 (.i_clk(i_clk), .i_en(en), .i_a(r_d11), .i_b(r_d20), .o_p(m11_20));
    bcc_wmul u_m01_21 (.i_clk(i_clk), .i_en(en), .i_a(r_d01), .i_b(r_d21), .o_p(m01_21));
    bcc_wmul u_m00_21 (.i_clk(i_clk), .i_en(en), .i_a(r_d00), .i_b(r_d21), .o_p(m00_21));
    bcc_wmul u_m01_20 (.i_clk(i_clk), .i_en(en), .i_a(r_d01), .i_b(r_d20), .o_p(m01_20));

    // stage 6: determinant and numerators
    logic signed [NW-1:0] r_det6, r_nb, r_nc;
    logic r_vld6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det6 <= NW'(m00_11) - NW'(m01_01);
            r_nb   <= NW'(m11_20) - NW'(m01_21);
            r_nc   <= NW'(m00_21) - NW'(m01_20);
        end
    end

    // stage 7: sign and magnitude of numerators
    logic [NW-1:0] r_det7, r_mb, r_mc;
    logic          r_negb, r_negc;
    logic r_vld7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det7 <= r_det6;
            r_negb <= r_nb[NW-1];
            r_negc <= r_nc[NW-1];
            r_mb   <= r_nb[NW-1] ? NW'(-r_nb) : r_nb;
            r_mc   <= r_nc[NW-1] ? NW'(-r_nc) : r_nc;
        end
    end

    // valid bits for stages 1-7
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_in_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6;
        end
    end

    // quotient dividers
    logic vb, vc, zb, zc;
    logic signed [WW-1:0] wb, wc;

    bcc_div u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_vld7),
        .i_neg(r_negb), .i_mag(r_mb), .i_det(r_det7),
        .o_vld(vb), .o_zero(zb), .o_weight(wb)
    );

    bcc_div u_div_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_vld7),
        .i_neg(r_negc), .i_mag(r_mc), .i_det(r_det7),
        .o_vld(vc), .o_zero(zc), .o_weight(wc)
    );

    // weight_a and degenerate masking
    logic signed [SW-1:0] wa_sum;
    logic signed [WW-1:0] wa;
    bcc_pkg::t_out fin;

    always_comb begin
        wa_sum = bcc_pkg::WeightOne - SW'(wb) - SW'(wc);
        if (wa_sum > bcc_pkg::WeightMax) begin
            wa = WW'(bcc_pkg::WeightMax);
        end else if (wa_sum < bcc_pkg::WeightMin) begin
            wa = WW'(bcc_pkg::WeightMin);
        end else begin
            wa = WW'(wa_sum);
        end
        fin.degenerate = zb;
        fin.weight_a   = zb ? '0 : wa;
        fin.weight_b   = zb ? '0 : wb;
        fin.weight_c   = zb ? '0 : wc;
    end

    // output register with one skid entry
    logic          r_out_vld;
    bcc_pkg::t_out r_out, r_skid;
    logic          take, push;

    assign take = r_out_vld && i_out_ready;
    assign push = vb && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (take) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (push) begin
                if (r_out_vld && !take) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end else if (take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_vld && !take) begin
                r_skid <= fin;
            end else begin
                r_out <= fin;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without output entry");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !take) |=> (r_skid_vld && $stable(r_skid)))
        else $error("waiting skid item lost or changed");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vb == vc) && (!vb || (zb == zc)))
        else $error("dividers out of step");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.degenerate) |->
        (r_out.weight_a == '0 && r_out.weight_b == '0 && r_out.weight_c == '0))
        else $error("degenerate item with nonzero weights");

endmodule
`default_nettype wire

// ===== test/triangle_barycentric_coords_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_coords_tb: self-checking bench for barycentric weights
// Drives query items through the valid/ready input, predicts each result with
// exact wide integer arithmetic and checks the outputs in order, with random
// idling on both sides and a long forced output stall.
// ----------------------------------------------------------------------------
module triangle_barycentric_coords_tb;

    localparam int ClkHalf = 6;
    localparam int Latency = 43;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    bcc_pkg::t_in  i_in_item;
    logic          o_out_valid;
    logic          i_out_ready;
    bcc_pkg::t_out o_out_item;

    bcc_pkg::t_out weights_due[$];
    int   n_fail;
    bit   out_hold;      // receiver forced to stall
    int   hold_cycles;   // length of the forced stall

    triangle_barycentric_coords dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #ClkHalf;
        i_clk = 1'b0;
        #ClkHalf;
    end

    // Rounded, saturated quotient num * 2^FracBits / det
    function automatic logic signed [bcc_pkg::WeightW-1:0] scaled_quotient(
        input logic signed [191:0] num, input logic signed [191:0] det);
        logic         neg;
        logic [191:0] mag;
        logic [191:0] q;
        logic [63:0]  lim;
        neg = num < 0;
        mag = neg ? -num : num;
        q = ((mag << (bcc_pkg::FracBits + 1)) / det + 1) >> 1;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -q[bcc_pkg::WeightW-1:0] : q[bcc_pkg::WeightW-1:0];
    endfunction

    // Barycentric weights of one query item
    function automatic bcc_pkg::t_out barycentric_weights(input bcc_pkg::t_in it);
        logic signed [191:0] ax, ay, az, v0[3], v1[3], v2[3];
        logic signed [191:0] d00, d01, d11, d20, d21, det, wb, wc, wa;
        bcc_pkg::t_out r;
        ax = it.a_x; ay = it.a_y; az = it.a_z;
        v0[0] = it.b_x - ax; v0[1] = it.b_y - ay; v0[2] = it.b_z - az;
        v1[0] = it.c_x - ax; v1[1] = it.c_y - ay; v1[2] = it.c_z - az;
        v2[0] = it.q_x - ax; v2[1] = it.q_y - ay; v2[2] = it.q_z - az;
        d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
        for (int k = 0; k < 3; k++) begin
            d00 += v0[k] * v0[k];
            d01 += v0[k] * v1[k];
            d11 += v1[k] * v1[k];
            d20 += v2[k] * v0[k];
            d21 += v2[k] * v1[k];
        end
        det = d00 * d11 - d01 * d01;
        r = '0;
        if (det == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        wb = scaled_quotient(d11 * d20 - d01 * d21, det);
        wc = scaled_quotient(d00 * d21 - d01 * d20, det);
        wa = (192'sd1 <<< bcc_pkg::FracBits) - wb - wc;
        if (wa > 192'sh7FFF_FFFF) wa = 192'sh7FFF_FFFF;
        if (wa < -192'sh8000_0000) wa = -192'sh8000_0000;
        r.weight_a = wa[bcc_pkg::WeightW-1:0];
        r.weight_b = wb[bcc_pkg::WeightW-1:0];
        r.weight_c = wc[bcc_pkg::WeightW-1:0];
        return r;
    endfunction

    // Send one item after a random gap; valid stays up until the next call
    task automatic send_query(input bcc_pkg::t_in it, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        weights_due.push_back(barycentric_weights(it));
        @(negedge i_clk);
    endtask

    function automatic bcc_pkg::t_field rand_field(input int mode);
        case (mode)
            0: return bcc_pkg::t_field'($urandom_range(0, 65535));
            1: return bcc_pkg::t_field'($signed($urandom_range(0, 40)) - 20);
            default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic bcc_pkg::t_in rand_query();
        bcc_pkg::t_in it;
        int  mode;
        int  shape;
        mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
        it = bcc_pkg::t_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.a_x = rand_field(mode); it.a_y = rand_field(mode); it.a_z = rand_field(mode);
        it.b_x = rand_field(mode); it.b_y = rand_field(mode); it.b_z = rand_field(mode);
        it.c_x = rand_field(mode); it.c_y = rand_field(mode); it.c_z = rand_field(mode);
        it.q_x = rand_field(mode); it.q_y = rand_field(mode); it.q_z = rand_field(mode);
        shape = $urandom_range(0, 9);
        // coincident or collinear vertices give det 0; shape 2 puts q on a
        if (shape == 0) begin
            it.c_x = it.b_x; it.c_y = it.b_y; it.c_z = it.b_z;
        end else if (shape == 1) begin
            it.c_x = bcc_pkg::t_field'(2 * it.b_x - it.a_x);
            it.c_y = bcc_pkg::t_field'(2 * it.b_y - it.a_y);
            it.c_z = bcc_pkg::t_field'(2 * it.b_z - it.a_z);
        end else if (shape == 2) begin
            it.q_x = it.a_x; it.q_y = it.a_y; it.q_z = it.a_z;
        end
        return it;
    endfunction

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (weights_due.size() != 0) @(negedge i_clk);
    endtask

    // Edge values, right triangle, vertex hits, degenerate cases
    task automatic test_directed();
        bcc_pkg::t_in it;
        it = '0;
        send_query(it);
        it = '0; it.b_x = 1; it.c_y = 1;
        send_query(it);
        it.q_x = 1; send_query(it);
        it.q_x = 0; it.q_y = 1; send_query(it);
        it.q_x = 1; it.q_y = 1; send_query(it);
        it = '0; it.b_x = 3; it.c_y = 3; it.q_x = 1; it.q_y = 1;
        send_query(it);
        it = '0; it.b_x = 16'sh7FFF; it.c_y = 16'sh7FFF; it.q_x = 16'sh8000;
        send_query(it);
        it = '{default: 16'sh8000};
        send_query(it);
        it = '{default: 16'sh7FFF};
        send_query(it);
        it = '{default: 16'sh8000}; it.b_x = 16'sh7FFF; it.c_y = 16'sh7FFF;
        it.q_z = 16'sh7FFF; send_query(it);
        it = '0; it.b_x = 1; it.c_y = 16'sh7FFF; it.q_x = 16'sh8000;
        it.q_y = 16'sh8000; send_query(it);
        it = '0; it.b_x = 16'sh7FFF; it.c_x = 16'sh8000; it.c_y = 1;
        it.q_y = 16'sh7FFF; send_query(it);
        it = '0; it.b_x = 2; it.c_x = 4; send_query(it);
        it = '0; it.b_x = 1; it.b_y = 1; it.c_x = 1; it.c_y = 2;
        it.q_x = 16'sh7FFF; it.q_y = 16'sh8000; it.q_z = 16'sh7FFF;
        send_query(it);
        drain_results();
    endtask

    // Back-to-back items into a stalled output
    task automatic test_backpressure();
        hold_cycles = 200;
        out_hold = 1'b1;
        for (int n = 0; n < 100; n++) send_query(rand_query(), 1);
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 256 < 40) send_query(rand_query(), 1);
            else send_query(rand_query());
        end
        drain_results();
    endtask

    // Receiver: random stalls, one forced long stall on request
    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                out_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        bcc_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (weights_due.size() == 0) begin
                $error("result with none expected: %h", o_out_item);
                n_fail++;
            end else begin
                want = weights_due.pop_front();
                if (o_out_item.weight_a !== want.weight_a) begin
                    $error("weight_a expected %0d got %0d", want.weight_a,
                           o_out_item.weight_a);
                    n_fail++;
                end
                if (o_out_item.weight_b !== want.weight_b) begin
                    $error("weight_b expected %0d got %0d", want.weight_b,
                           o_out_item.weight_b);
                    n_fail++;
                end
                if (o_out_item.weight_c !== want.weight_c) begin
                    $error("weight_c expected %0d got %0d", want.weight_c,
                           o_out_item.weight_c);
                    n_fail++;
                end
                if (o_out_item.degenerate !== want.degenerate) begin
                    $error("degenerate expected %0b got %0b", want.degenerate,
                           o_out_item.degenerate);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        n_fail = 0;
        out_hold = 1'b0;
        hold_cycles = 0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(1030);
        repeat (Latency + 10) @(negedge i_clk);
        if (weights_due.size() != 0) n_fail++;
        if (n_fail == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== triangle_barycentric_coords.f =====
rtl/bcc_pkg.sv
rtl/bcc_wmul.sv
rtl/bcc_div.sv
rtl/triangle_barycentric_coords.sv
test/triangle_barycentric_coords_tb.sv
